### sv/ngts_pkg.sv
// ----------------------------------------------------------------------------
// ngts_pkg - shared types and constants of the nearest gene TSS search
// Table sizing, command and status codes, entry layout and stream widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ngts_pkg;

    // Table sizing
    localparam int MAX_GENES   = 4096;
    localparam int CHROM_CODES = 256;
    localparam int ADDR_W      = $clog2(MAX_GENES);
    localparam int COUNT_W     = $clog2(MAX_GENES + 1);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CHROM_W  = 8;
    localparam int POS_W    = 31;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 12;
    localparam int DIST_W   = 32;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = ((CHROM_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((INDEX_W + DIST_W + 7) / 8) * 8;

    // Largest magnitude that is never taken
    localparam logic [POS_W-1:0] NO_TAKE_MAG = {POS_W{1'b1}};

    // Commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ANY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRIOR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_AFTER = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // One table entry
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
    } entry_t;

    // Write port of the entry table
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } tbl_wr_t;

endpackage : ngts_pkg

`default_nettype wire

### sv/ngts_entry_table.sv
// ----------------------------------------------------------------------------
// ngts_entry_table - gene entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ngts_entry_table
    import ngts_pkg::*;
(
    input  wire logic              aclk,
    input  wire tbl_wr_t           wr,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [MAX_GENES];

    // Store one entry on a write
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : ngts_entry_table

`default_nettype wire

### sv/nearest_gene_tss_search_top.sv
// ----------------------------------------------------------------------------
// nearest_gene_tss_search_top - nearest transcription start search
// Appends gene entries to a table and scans it for the entry nearest to a
// query position on the same chromosome, in either direction or only on one side.
//
// Channel  Dir  Ports                        Contents
// s_       in   s_tvalid s_tready            tuser: command
//               s_tdata s_tuser              tdata: chrom_code, position
// m_       out  m_tvalid m_tready            tuser: status
//               m_tdata m_tuser              tdata: gene_index, distance
//
// For an add, the result passes from the response state into the output
// register. For a query, the single read port of the entry table delivers
// one entry per cycle to the shared distance/compare unit, through the read
// data, distance and best-pick registers; the pick then goes to the result
// register and is loaded into the output register (no entry is read when empty).
// The input is not ready while a transaction is being worked on.
// Reset clears the entry count; the table contents are left as they are.
// A stalled result holds in the output register; the next transaction may be
// accepted meanwhile and waits to load until the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_gene_tss_search_top
    import ngts_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // chrom_code, position, pad
    input  wire logic [CMD_W-1:0]     s_tuser,  // command
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // gene_index, distance, pad
    output logic [STATUS_W-1:0]       m_tuser   // status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [CHROM_W-1:0]  qchrom_reg;
    logic [POS_W-1:0]    qpos_reg;
    logic [COUNT_W-1:0]  issue_reg;

    logic                s1_valid_reg;
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic                s2_valid_reg;
    logic                s2_qual_reg;
    logic [POS_W-1:0]    s2_mag_reg;
    logic [DIST_W-1:0]   s2_dist_reg;
    logic [ADDR_W-1:0]   s2_idx_reg;

    logic [POS_W-1:0]    best_mag_reg;
    logic [ADDR_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic                found_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [INDEX_W-1:0]  res_index_reg;
    logic [DIST_W-1:0]   res_dist_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [DIST_W-1:0]   m_dist_reg;

    logic                in_accept;
    logic [CHROM_W-1:0]  in_chrom;
    logic [POS_W-1:0]    in_pos;
    logic                table_full;
    logic                rd_en;
    logic                scan_done;
    logic                out_load;
    tbl_wr_t             tbl_wr;
    entry_t              rd_data;

    logic [DIST_W-1:0]   diff;
    logic [DIST_W-1:0]   neg_diff;
    logic                at_before;
    logic                at_after;
    logic                dir_ok;
    logic                take;

    // Unpack the input transaction
    assign in_accept  = s_tvalid && s_tready;
    assign in_chrom   = CHROM_W'(32'(s_tdata[CHROM_W-1:0]) % CHROM_CODES);
    assign in_pos     = s_tdata[CHROM_W +: POS_W];
    assign table_full = (count_reg == COUNT_W'(MAX_GENES));
    assign s_tready   = (state_reg == S_IDLE);

    // Append an entry on an add that fits
    always_comb begin
        tbl_wr.en         = in_accept && (s_tuser == CMD_ADD) && !table_full;
        tbl_wr.addr       = count_reg[ADDR_W-1:0];
        tbl_wr.data.chrom = in_chrom;
        tbl_wr.data.start = in_pos;
    end

    assign rd_en = (state_reg == S_SCAN) && (issue_reg < count_reg);

    ngts_entry_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Distance unit: signed offset, direction and magnitude of one entry
    always_comb begin
        diff      = {1'b0, qpos_reg} - {1'b0, rd_data.start};
        neg_diff  = DIST_W'(0) - diff;
        at_before = !diff[DIST_W-1];
        at_after  = diff[DIST_W-1] || (diff == '0);
        unique case (cmd_reg)
            CMD_ANY:   dir_ok = 1'b1;
            CMD_PRIOR: dir_ok = at_before;
            CMD_AFTER: dir_ok = at_after;
            CMD_ADD:   dir_ok = 1'b0;
        endcase
    end

    // Compare unit: only a strictly smaller magnitude replaces the pick
    assign take = s2_valid_reg && s2_qual_reg && (s2_mag_reg < best_mag_reg);

    assign scan_done = (state_reg == S_SCAN) && (issue_reg == count_reg) &&
                       !s1_valid_reg && !s2_valid_reg;
    assign out_load  = (state_reg == S_RESP) && (!m_valid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = (s_tuser == CMD_ADD) ? S_RESP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            if (tbl_wr.en) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the query and advance the read pointer
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg    <= s_tuser;
            qchrom_reg <= in_chrom;
            qpos_reg   <= in_pos;
            issue_reg  <= '0;
        end else if (rd_en) begin
            issue_reg <= issue_reg + COUNT_W'(1);
        end
    end

    // Scan pipeline: index follows the read, then distance is registered
    always_ff @(posedge aclk) begin
        s1_idx_reg  <= issue_reg[ADDR_W-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s2_qual_reg <= (rd_data.chrom == qchrom_reg) && dir_ok;
        s2_mag_reg  <= at_before ? diff[POS_W-1:0] : neg_diff[POS_W-1:0];
        s2_dist_reg <= diff;
    end

    // Running best pick
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            best_mag_reg <= NO_TAKE_MAG;
            found_reg    <= 1'b0;
        end else if (take) begin
            best_mag_reg  <= s2_mag_reg;
            best_idx_reg  <= s2_idx_reg;
            best_dist_reg <= s2_dist_reg;
            found_reg     <= 1'b1;
        end
    end

    // Result of the transaction in flight
    always_ff @(posedge aclk) begin
        if (in_accept && (s_tuser == CMD_ADD)) begin
            res_status_reg <= table_full ? STATUS_FULL : STATUS_OK;
            res_index_reg  <= table_full ? '0 : INDEX_W'(count_reg);
            res_dist_reg   <= '0;
        end else if (scan_done) begin
            res_status_reg <= found_reg ? STATUS_OK : STATUS_NONE;
            res_index_reg  <= found_reg ? INDEX_W'(best_idx_reg) : '0;
            res_dist_reg   <= found_reg ? best_dist_reg : '0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_dist_reg   <= res_dist_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - INDEX_W - DIST_W){1'b0}}, m_dist_reg, m_index_reg};

endmodule : nearest_gene_tss_search_top

`default_nettype wire

### sv/ngts_checker.sv
// ----------------------------------------------------------------------------
// ngts_checker - port checks of the nearest gene TSS search
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ngts_checker
    import ngts_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic [CMD_W-1:0]     s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [STATUS_W-1:0]  m_tuser
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_NONE ||
                      m_tuser == STATUS_FULL))
        else $error("undefined status code");

    // A failed transaction carries zero index and distance
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_OK) |-> (m_tdata == '0))
        else $error("nonzero payload on failed transaction");

    // One transaction at a time: input closes after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after acceptance");

    // Payload of the input is not checked beyond its handshake
    logic unused_in;
    assign unused_in = ^{s_tdata, s_tuser};

endmodule : ngts_checker

bind nearest_gene_tss_search_top ngts_checker u_ngts_checker (.*);

`default_nettype wire
